@@ design/twp_pkg.sv @@
// Types, sizes and sequencer states shared by the three-way partition block.
package twp_pkg;

    localparam int MAX_ELEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ELEMS);
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int DATA_W    = 16;
    localparam int PICK_W    = 6;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     batch_end;
        logic        [PICK_W-1:0] pivot_pick;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     run_end;
    } out_item_t;

    // Element store port requests from the sequencer.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIVOT_RD,
        ST_PIVOT_LD,
        ST_CHECK,
        ST_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

@@ design/twp_ram.sv @@
// Simple dual-port element store: one write port, one registered read port.
module twp_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/three_way_partition.sv @@
// Top level of the three-way (Dutch national flag) partition block.

// Samples arrive one per transfer and are written to a 64-entry element store
// in arrival order; samples beyond 64 are dropped. The transfer that carries
// batch_end also carries pivot_pick (clamped to the last stored element). The
// block then stops taking input, reads the pivot, and partitions the store in
// place with low, mid and high pointers, using one registered-read memory port
// and one signed comparator over and over. After that it streams the batch
// out in its new order (smaller, equal, greater), marking the final result
// with run_end. Steps: the load takes one sample per transfer (s_ready high),
// ST_PIVOT_RD and ST_PIVOT_LD fetch the pivot, each partition step runs
// ST_CHECK and ST_CMP, plus ST_SWAP_A and ST_SWAP_B when the element moves
// (the single write port writes one word at a time), a last ST_CHECK closes
// the partition, and each result runs ST_EMIT_RD and ST_EMIT_LD on the way
// out, plus any m_ready stall. The output register lets the final result
// wait while the next batch is already loading.
module three_way_partition (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  twp_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output twp_pkg::out_item_t m_data
);

    localparam int ADDR_W = twp_pkg::ADDR_W;
    localparam int CNT_W  = twp_pkg::CNT_W;
    localparam int DATA_W = twp_pkg::DATA_W;

    twp_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  fill_reg,  fill_next;   // elements stored / batch length
    logic [CNT_W-1:0]  lo_reg,    lo_next;
    logic [CNT_W-1:0]  md_reg,    md_next;
    logic [CNT_W-1:0]  hip1_reg,  hip1_next;   // high pointer plus one
    logic [CNT_W-1:0]  k_reg,     k_next;      // emit index
    logic [twp_pkg::PICK_W-1:0] pick_reg, pick_next;
    logic signed [DATA_W-1:0]   pivot_reg, pivot_next;
    logic signed [DATA_W-1:0]   val_reg,   val_next;
    logic                       less_reg,  less_next;
    logic                       m_valid_reg, m_valid_next;
    twp_pkg::out_item_t         out_reg,   out_next;

    twp_pkg::ram_req_t ram_req;
    logic [DATA_W-1:0] ram_rdata;

    logic signed [DATA_W-1:0] rd_val;
    logic [CNT_W-1:0]         last_idx;
    logic [CNT_W-1:0]         hi_idx;

    twp_ram #(
        .DEPTH (twp_pkg::MAX_ELEMS),
        .WIDTH (DATA_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign rd_val   = $signed(ram_rdata);
    assign last_idx = fill_reg - CNT_W'(1);
    assign hi_idx   = hip1_reg - CNT_W'(1);

    assign s_ready = (state_reg == twp_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= twp_pkg::ST_IDLE;
            fill_reg    <= '0;
            lo_reg      <= '0;
            md_reg      <= '0;
            hip1_reg    <= '0;
            k_reg       <= '0;
            pivot_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            lo_reg      <= lo_next;
            md_reg      <= md_next;
            hip1_reg    <= hip1_next;
            k_reg       <= k_next;
            pivot_reg   <= pivot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pick_reg <= pick_next;
        val_reg  <= val_next;
        less_reg <= less_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        lo_next      = lo_reg;
        md_next      = md_reg;
        hip1_next    = hip1_reg;
        k_next       = k_reg;
        pick_next    = pick_reg;
        pivot_next   = pivot_reg;
        val_next     = val_reg;
        less_next    = less_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_req      = '0;

        unique case (state_reg)
            twp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    // full store: sample dropped, batch_end still honored
                    if (fill_reg < CNT_W'(twp_pkg::MAX_ELEMS)) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = fill_reg[ADDR_W-1:0];
                        ram_req.wdata = s_data.sample_value;
                        fill_next     = fill_reg + CNT_W'(1);
                    end
                    pick_next = s_data.pivot_pick;
                    if (s_data.batch_end) begin
                        state_next = twp_pkg::ST_PIVOT_RD;
                    end
                end
            end
            twp_pkg::ST_PIVOT_RD: begin
                ram_req.re = 1'b1;
                if (int'(pick_reg) > int'(last_idx)) begin
                    ram_req.raddr = last_idx[ADDR_W-1:0];
                end else begin
                    ram_req.raddr = ADDR_W'(pick_reg);
                end
                state_next = twp_pkg::ST_PIVOT_LD;
            end
            twp_pkg::ST_PIVOT_LD: begin
                pivot_next = rd_val;
                lo_next    = '0;
                md_next    = '0;
                hip1_next  = fill_reg;
                state_next = twp_pkg::ST_CHECK;
            end
            twp_pkg::ST_CHECK: begin
                if (md_reg < hip1_reg) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = md_reg[ADDR_W-1:0];
                    state_next    = twp_pkg::ST_CMP;
                end else begin
                    k_next     = '0;
                    state_next = twp_pkg::ST_EMIT_RD;
                end
            end
            twp_pkg::ST_CMP: begin
                val_next = rd_val;
                if (rd_val < pivot_reg) begin
                    less_next     = 1'b1;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = lo_reg[ADDR_W-1:0];
                    state_next    = twp_pkg::ST_SWAP_A;
                end else if (rd_val > pivot_reg) begin
                    less_next     = 1'b0;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = hi_idx[ADDR_W-1:0];
                    state_next    = twp_pkg::ST_SWAP_A;
                end else begin
                    md_next    = md_reg + CNT_W'(1);
                    state_next = twp_pkg::ST_CHECK;
                end
            end
            twp_pkg::ST_SWAP_A: begin
                // mid element goes to the partner slot
                ram_req.we    = 1'b1;
                ram_req.waddr = less_reg ? lo_reg[ADDR_W-1:0] : hi_idx[ADDR_W-1:0];
                ram_req.wdata = val_reg;
                state_next    = twp_pkg::ST_SWAP_B;
            end
            twp_pkg::ST_SWAP_B: begin
                // partner element (still in read register) goes to mid
                ram_req.we    = 1'b1;
                ram_req.waddr = md_reg[ADDR_W-1:0];
                ram_req.wdata = ram_rdata;
                if (less_reg) begin
                    lo_next = lo_reg + CNT_W'(1);
                    md_next = md_reg + CNT_W'(1);
                end else begin
                    hip1_next = hi_idx;
                end
                state_next = twp_pkg::ST_CHECK;
            end
            twp_pkg::ST_EMIT_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = k_reg[ADDR_W-1:0];
                state_next    = twp_pkg::ST_EMIT_LD;
            end
            twp_pkg::ST_EMIT_LD: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.sorted_value = rd_val;
                    out_next.run_end      = (k_reg == last_idx);
                    m_valid_next          = 1'b1;
                    k_next                = k_reg + CNT_W'(1);
                    if (k_reg == last_idx) begin
                        fill_next  = '0;
                        state_next = twp_pkg::ST_IDLE;
                    end else begin
                        state_next = twp_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = twp_pkg::ST_IDLE;
            end
        endcase
    end

    // Store never overfills.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(twp_pkg::MAX_ELEMS))
        else $error("fill count beyond store depth");

    // Partition pointers stay ordered: low <= mid <= high+1.
    a_ptr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == twp_pkg::ST_CHECK) |-> (lo_reg <= md_reg && md_reg <= hip1_reg))
        else $error("partition pointers out of order");

    // A closing transfer starts the pivot fetch next cycle.
    a_batch_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.batch_end) |=> (state_reg == twp_pkg::ST_PIVOT_RD))
        else $error("batch end did not start partition");

    // Emission only runs over a non-empty batch.
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == twp_pkg::ST_EMIT_LD) |-> (fill_reg != '0 && k_reg < fill_reg))
        else $error("emit index outside batch");

endmodule

@@ dv/three_way_partition_tb.sv @@
// Self-checking testbench for the three-way partition block.
`timescale 1ns / 1ps

module three_way_partition_tb;

    localparam int DATA_W       = twp_pkg::DATA_W;
    localparam int PICK_W       = twp_pkg::PICK_W;
    localparam int MAX_ELEMS    = twp_pkg::MAX_ELEMS;
    localparam int RANDOM_ITEMS = 430;
    localparam int HOLD_AT      = 120;   // results seen before the long m_ready hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 400;   // quiet cycles after the last expected result

    typedef struct {
        twp_pkg::in_item_t  item;
        bit                 typed;    // expected result written in the row
        twp_pkg::out_item_t result;
    } plan_row_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    twp_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    twp_pkg::out_item_t m_data;

    // Predictor state: elements of the batch being loaded.
    logic signed [DATA_W-1:0] held [MAX_ELEMS];
    int                       held_count = 0;
    twp_pkg::out_item_t       sorted_due [$];

    int                 fail_count   = 0;
    int                 results_seen = 0;
    int                 rx_wait      = 0;
    int                 rx_hold      = 0;
    bit                 hold_done    = 1'b0;
    bit                 rx_quiet     = 1'b0;
    bit                 tx_quiet     = 1'b0;
    twp_pkg::out_item_t due;

    plan_row_t plan [$];

    three_way_partition u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Store one accepted sample; on batch end, partition and queue the reordered batch.
    function automatic void absorb_sample(twp_pkg::in_item_t it, bit keep);
        logic signed [DATA_W-1:0] pv;
        logic signed [DATA_W-1:0] tmp;
        int n, pk, lo, md, hi;
        twp_pkg::out_item_t res;
        if (held_count < MAX_ELEMS) begin
            held[held_count] = it.sample_value;
            held_count++;
        end
        if (!it.batch_end) return;
        n  = held_count;
        pk = int'(it.pivot_pick);
        if (pk > n - 1) pk = n - 1;
        pv = held[pk];
        lo = 0;
        md = 0;
        hi = n - 1;
        while (md <= hi) begin
            if (held[md] < pv) begin
                tmp = held[lo]; held[lo] = held[md]; held[md] = tmp;
                lo++;
                md++;
            end else if (held[md] > pv) begin
                tmp = held[md]; held[md] = held[hi]; held[hi] = tmp;
                hi--;
            end else begin
                md++;
            end
        end
        if (keep) begin
            for (int k = 0; k < n; k++) begin
                res.sorted_value = held[k];
                res.run_end      = (k == n - 1);
                sorted_due.push_back(res);
            end
        end
        held_count = 0;
    endfunction

    function automatic plan_row_t mk_row(int v, bit last, int pick, bit typed);
        plan_row_t r;
        r.item.sample_value = v[DATA_W-1:0];
        r.item.batch_end    = last;
        r.item.pivot_pick   = pick[PICK_W-1:0];
        r.typed             = typed;
        r.result.sorted_value = v[DATA_W-1:0];
        r.result.run_end      = 1'b1;
        return r;
    endfunction

    function automatic int tx_gap();
        return tx_quiet ? 0 : $urandom_range(0, 9);
    endfunction

    // Offer one item after a gap and return at the edge where it transfers.
    task automatic send_item(twp_pkg::in_item_t it, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Result side: random m_ready stalls, one long hold-off, and the scoreboard check.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (sorted_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no result, actual value=%0d run_end=%0b",
                             $time, m_data.sorted_value, m_data.run_end);
                end else begin
                    due = sorted_due.pop_front();
                    if (m_data.sorted_value !== due.sorted_value ||
                        m_data.run_end !== due.run_end) begin
                        fail_count++;
                        $display("%0t: expected %0d/%0b actual %0d/%0b",
                                 $time, due.sorted_value, due.run_end,
                                 m_data.sorted_value, m_data.run_end);
                    end
                end
                results_seen++;
                if (results_seen % 100 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
                if (results_seen == HOLD_AT && !hold_done) begin
                    rx_hold   = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int                sent;
        int                batch_no;
        int                len;
        int                mode;
        int                r;
        twp_pkg::in_item_t it;

        // single-element batches: the result is the element itself
        plan.push_back(mk_row(32767, 1'b1, 0, 1'b1));
        plan.push_back(mk_row(-32768, 1'b1, 63, 1'b1));   // pivot past the batch
        plan.push_back(mk_row(0, 1'b1, 0, 1'b1));
        // mixed batch with duplicates of the pivot
        plan.push_back(mk_row(3, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(-1, 1'b0, 63, 1'b0));
        plan.push_back(mk_row(3, 1'b0, 21, 1'b0));
        plan.push_back(mk_row(7, 1'b0, 42, 1'b0));
        plan.push_back(mk_row(-5, 1'b1, 2, 1'b0));
        // extremes, pivot clamped to the last element
        plan.push_back(mk_row(-32768, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(32767, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(0, 1'b1, 40, 1'b0));
        // all equal
        plan.push_back(mk_row(9, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(9, 1'b1, 1, 1'b0));
        // descending, middle pivot
        plan.push_back(mk_row(3, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(2, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(1, 1'b1, 1, 1'b0));
        // pivot at the first element, others all greater
        plan.push_back(mk_row(-7, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(100, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(-1, 1'b1, 0, 1'b0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            send_item(plan[i].item, tx_gap());
            absorb_sample(plan[i].item, !plan[i].typed);
            if (plan[i].typed) sorted_due.push_back(plan[i].result);
        end

        sent     = 0;
        batch_no = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(1, 8);
            else if (r < 88) len = $urandom_range(9, 24);
            else if (r < 95) len = MAX_ELEMS;
            else             len = $urandom_range(MAX_ELEMS + 1, MAX_ELEMS + 6);  // overflow drops
            mode     = $urandom_range(0, 2);
            tx_quiet = ($urandom_range(0, 3) == 0);

            // let the whole pipeline run dry once mid-run
            if (batch_no == 12) begin
                s_valid <= 1'b0;
                while (sorted_due.size() != 0) @(posedge aclk);
            end

            for (int k = 0; k < len; k++) begin
                case (mode)
                    0: it.sample_value = DATA_W'($urandom);
                    1: it.sample_value = DATA_W'($signed($urandom_range(0, 6)) - 3);
                    default: begin
                        case ($urandom_range(0, 3))
                            0: it.sample_value = -16'sh8000;
                            1: it.sample_value = 16'sh7FFF;
                            2: it.sample_value = '0;
                            default: it.sample_value = '1;
                        endcase
                    end
                endcase
                it.batch_end = (k == len - 1);
                if (it.batch_end && $urandom_range(0, 99) < 85)
                    it.pivot_pick = PICK_W'($urandom_range(0,
                                        (len > MAX_ELEMS ? MAX_ELEMS : len) - 1));
                else
                    it.pivot_pick = PICK_W'($urandom_range(0, 63));
                send_item(it, tx_gap());
                absorb_sample(it, 1'b1);
                sent++;
            end
            batch_no++;
        end
        s_valid <= 1'b0;

        while (sorted_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
